// ===== design/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies; clock aclk and reset aresetn are taken from the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define BEA_ASSERT_IMPL(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("assertion failed");

// expression must never be true outside reset
`define BEA_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("forbidden condition seen");

`endif

// ===== design/bea_pkg.sv =====
// shared types, constants and the pad remap function for the button event block
// no dependencies
package bea_pkg;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_REPEAT  = 2'd1,
        EV_RELEASE = 2'd2
    } event_kind_t;

    localparam int NUM_MAP     = 14;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] COUNT_RELOAD = 32'd16;
    localparam logic [31:0] COUNT_STEP   = 32'd2;
    localparam logic signed [31:0] FAST_LIMIT   = -32'sd90;
    localparam logic signed [31:0] SCROLL_LIMIT = -32'sd299;
    localparam int SUPPRESS_BIT = 6;

    // fixed wiring from pad bits to button bits
    localparam logic [4:0] PAD_IDX [NUM_MAP] = '{
        5'd3, 5'd5, 5'd6, 5'd4, 5'd29, 5'd30, 5'd28,
        5'd31, 5'd26, 5'd27, 5'd24, 5'd25, 5'd1, 5'd2
    };
    localparam logic [3:0] BTN_IDX [NUM_MAP] = '{
        4'd12, 4'd14, 4'd15, 4'd13, 4'd5, 4'd6, 4'd4,
        4'd7, 4'd2, 4'd3, 4'd0, 4'd1, 4'd8, 4'd11
    };

    // one classified tick: up to a release event and a press or repeat event
    typedef struct packed {
        logic        has_rel;
        logic [15:0] rel_mask;
        logic        has_pe;
        event_kind_t pe_kind;
        logic [15:0] pe_mask;
        logic        fast_scroll;
    } event_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [15:0] remap(input logic [31:0] pad);
        logic [15:0] r;
        r = '0;
        for (int i = 0; i < NUM_MAP; i++) begin
            if (pad[PAD_IDX[i]]) begin
                r[BTN_IDX[i]] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// ===== design/button_edge_autorepeat_events_top.sv =====
// the first event of a tick reaches the m_ ports from its input transaction through the
//   queue write, then the back end's output register
// throughput: one input transaction per cycle while the record queue has room;
//   one event per cycle out while m_ready is high and a record is queued, and a release plus press is two events
// the back end's single output register sets the drain rate of one event per ready cycle
// reset: synchronous, active low; clears arming, button history, countdown, queue, output
`include "assert_macros.svh"

module button_edge_autorepeat_events_top #(
    parameter int QUEUE_DEPTH = bea_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // poll tick input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_pad_word,
    input  logic        s_rapid_mode,
    // event output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic [15:0] m_event_buttons,
    output logic        m_fast_scroll,
    output logic        m_last_event
);

    // classified record travelling from front to back
    bea_pkg::event_rec_t    push_rec;
    bea_pkg::event_rec_t    head_rec;
    bea_pkg::queue_status_t q_status;
    logic push;
    logic pop;
    // a release transaction that still has its press or repeat to follow
    logic rel_pair_start;

    // front: remap, arming, countdown and event classification
    bea_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .pad_word    (s_pad_word),
        .rapid_mode  (s_rapid_mode),
        .q_status    (q_status),
        .push        (push),
        .rec         (push_rec)
    );

    // queue decouples tick acceptance from event delivery
    bea_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .status   (q_status)
    );

    // back: release event first, then press or repeat, through the output register
    bea_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_rec      (head_rec),
        .q_status      (q_status),
        .pop           (pop),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .event_kind    (m_event_kind),
        .event_buttons (m_event_buttons),
        .fast_scroll   (m_fast_scroll),
        .last_event    (m_last_event)
    );

    assign rel_pair_start = m_valid && m_ready && !m_last_event &&
                            m_event_kind == 2'(bea_pkg::EV_RELEASE);

    // a record is only pushed when the queue has room
    `BEA_ASSERT_NEVER(a_queue_no_overflow, push && q_status.full)
    // the back end never pops an empty queue
    `BEA_ASSERT_NEVER(a_queue_no_underflow, pop && q_status.empty)
    // every delivered event names at least one button
    `BEA_ASSERT_NEVER(a_event_has_buttons, m_valid && m_event_buttons == 16'h0000)
    // a release that is not last is followed at once by its press or repeat
    `BEA_ASSERT_IMPL(a_release_pair, rel_pair_start |=> m_valid && m_event_kind != 2'(bea_pkg::EV_RELEASE))

endmodule

// ===== design/bea_front.sv =====
// front end: accepts poll ticks, keeps arming, button and countdown state,
// classifies each tick into an event record; uses bea_pkg
module bea_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         pad_word,
    input  logic                rapid_mode,
    input  bea_pkg::queue_status_t q_status,
    output logic                push,
    output bea_pkg::event_rec_t rec
);

    logic        armed_reg, armed_next;
    logic [15:0] prev_reg, prev_next;
    logic [31:0] count_reg, count_next;

    logic        accept;
    logic [15:0] buttons;
    logic [15:0] released;
    logic [15:0] pressed;
    logic        repeating;
    logic        press_ok;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign buttons  = bea_pkg::remap(pad_word);

    always_comb begin
        armed_next = armed_reg;
        prev_next  = prev_reg;
        count_next = count_reg;
        push       = 1'b0;

        released   = prev_reg & ~buttons;
        count_next = ((prev_reg != buttons) ? bea_pkg::COUNT_RELOAD : count_reg)
                     - bea_pkg::COUNT_STEP;
        repeating  = $signed(count_next) < 0 &&
                     ((rapid_mode && $signed(count_next) < bea_pkg::FAST_LIMIT) ||
                      count_next[1:0] == 2'b00);
        pressed    = buttons & ~(repeating ? 16'h0000 : prev_reg);
        press_ok   = (pressed != '0) && !(repeating && pressed[bea_pkg::SUPPRESS_BIT]);

        rec.has_rel     = released != '0;
        rec.rel_mask    = released;
        rec.has_pe      = press_ok;
        rec.pe_kind     = repeating ? bea_pkg::EV_REPEAT : bea_pkg::EV_PRESS;
        rec.pe_mask     = pressed;
        rec.fast_scroll = $signed(count_next) < bea_pkg::SCROLL_LIMIT;

        if (!accept) begin
            count_next = count_reg;
        end else if (!armed_reg) begin
            count_next = count_reg;
            if (buttons == '0) begin
                armed_next = 1'b1;
            end
        end else begin
            prev_next = buttons;
            push      = rec.has_rel || rec.has_pe;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
            prev_reg  <= '0;
            count_reg <= '0;
        end else begin
            armed_reg <= armed_next;
            prev_reg  <= prev_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/bea_queue.sv =====
// short queue of event records between front and back
// uses bea_pkg
module bea_queue #(
    parameter int DEPTH = bea_pkg::QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  bea_pkg::event_rec_t    push_rec,
    input  logic                   pop,
    output bea_pkg::event_rec_t    head_rec,
    output bea_pkg::queue_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    bea_pkg::event_rec_t slot_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign status.full  = cnt_reg == FULL_CNT;
    assign status.empty = cnt_reg == '0;
    assign do_push  = push && !status.full;
    assign do_pop   = pop && !status.empty;
    assign head_rec = slot_reg[rd_reg];

    always_comb begin
        wr_next  = do_push ? ((wr_reg == LAST_PTR) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop  ? ((rd_reg == LAST_PTR) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_reg] <= push_rec;
        end
    end

endmodule

// ===== design/bea_back.sv =====
// back end: expands each queued record into one or two events on an output register
// uses bea_pkg
module bea_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bea_pkg::event_rec_t    head_rec,
    input  bea_pkg::queue_status_t q_status,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             event_kind,
    output logic [15:0]            event_buttons,
    output logic                   fast_scroll,
    output logic                   last_event
);

    logic        valid_reg, valid_next;
    logic        phase_reg, phase_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] btn_reg, btn_next;
    logic        fs_reg, fs_next;
    logic        last_reg, last_next;
    logic        load, sel_rel;

    assign load    = !q_status.empty && (!valid_reg || out_ready);
    assign sel_rel = head_rec.has_rel && !phase_reg;

    always_comb begin
        valid_next = valid_reg && !out_ready;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        btn_next   = btn_reg;
        fs_next    = fs_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            fs_next    = head_rec.fast_scroll;
            if (sel_rel) begin
                kind_next  = bea_pkg::EV_RELEASE;
                btn_next   = head_rec.rel_mask;
                last_next  = !head_rec.has_pe;
                pop        = !head_rec.has_pe;
                phase_next = head_rec.has_pe;
            end else begin
                kind_next  = head_rec.pe_kind;
                btn_next   = head_rec.pe_mask;
                last_next  = 1'b1;
                pop        = 1'b1;
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        btn_reg  <= btn_next;
        fs_reg   <= fs_next;
        last_reg <= last_next;
    end

    assign out_valid     = valid_reg;
    assign event_kind    = kind_reg;
    assign event_buttons = btn_reg;
    assign fast_scroll   = fs_reg;
    assign last_event    = last_reg;

endmodule

// ===== tb/sv/button_event_scoreboard_pkg.sv =====
// scoreboard class for the button edge and auto-repeat event block
// depends on bea_pkg for the event kinds and the countdown constants
`timescale 1ns / 100ps

package button_event_scoreboard_pkg;

    import bea_pkg::*;

    typedef struct packed {
        event_kind_t kind;
        logic [15:0] buttons;
        logic        scroll;
        logic        last_flag;
    } button_event_t;

    class button_event_scoreboard;

        // copy of the block's state
        bit          armed;
        logic [15:0] prev_buttons;
        logic [31:0] countdown;

        button_event_t expected_events[$];

        int mismatches;
        int press_seen;
        int repeat_seen;
        int release_seen;
        int scroll_seen;
        int suppressed_repeats;

        function new();
            armed              = 1'b0;
            prev_buttons       = '0;
            countdown          = '0;
            mismatches         = 0;
            press_seen         = 0;
            repeat_seen        = 0;
            release_seen       = 0;
            scroll_seen        = 0;
            suppressed_repeats = 0;
        endfunction

        // fixed pad wiring, 14 of 32 pad bits
        function logic [15:0] pad_to_buttons(logic [31:0] pad);
            logic [15:0] b;
            b     = '0;
            b[0]  = pad[24];
            b[1]  = pad[25];
            b[2]  = pad[26];
            b[3]  = pad[27];
            b[4]  = pad[28];
            b[5]  = pad[29];
            b[6]  = pad[30];
            b[7]  = pad[31];
            b[8]  = pad[1];
            b[11] = pad[2];
            b[12] = pad[3];
            b[13] = pad[4];
            b[14] = pad[5];
            b[15] = pad[6];
            return b;
        endfunction

        // one accepted poll tick
        function void note_tick(logic [31:0] pad, logic fast);
            logic [15:0]        held;
            logic [15:0]        seen;
            logic [15:0]        released;
            logic [15:0]        pressed;
            logic signed [31:0] level;
            logic               scroll;
            bit                 repeating;
            int                 first_new;
            button_event_t      ev;
            held = pad_to_buttons(pad);
            if (!armed) begin
                if (held == '0) begin
                    armed = 1'b1;
                end
                return;
            end
            seen     = prev_buttons;
            released = seen & ~held;
            if (seen != held) begin
                countdown = COUNT_RELOAD;
            end
            countdown = countdown - COUNT_STEP;
            level     = countdown;
            repeating = (level < 0) &&
                        ((fast && level < FAST_LIMIT) || countdown[1:0] == 2'b00);
            if (repeating) begin
                seen = '0;
            end
            scroll    = (level < SCROLL_LIMIT);
            first_new = expected_events.size();
            if (released != '0) begin
                ev.kind      = EV_RELEASE;
                ev.buttons   = released;
                ev.scroll    = scroll;
                ev.last_flag = 1'b0;
                expected_events.push_back(ev);
            end
            pressed = held & ~seen;
            if (pressed != '0) begin
                if (repeating && pressed[SUPPRESS_BIT]) begin
                    suppressed_repeats++;
                end else begin
                    ev.kind      = repeating ? EV_REPEAT : EV_PRESS;
                    ev.buttons   = pressed;
                    ev.scroll    = scroll;
                    ev.last_flag = 1'b0;
                    expected_events.push_back(ev);
                end
            end
            prev_buttons = held;
            if (expected_events.size() > first_new) begin
                expected_events[expected_events.size() - 1].last_flag = 1'b1;
            end
        endfunction

        // one accepted event against the oldest expectation
        function void check_event(logic [1:0] kind, logic [15:0] buttons,
                                  logic scroll, logic last_flag);
            button_event_t want;
            if (expected_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected event: kind %0d buttons %h scroll %0d last %0d",
                             kind, buttons, scroll, last_flag);
                end
                return;
            end
            want = expected_events.pop_front();
            if (kind !== want.kind || buttons !== want.buttons ||
                scroll !== want.scroll || last_flag !== want.last_flag) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("event mismatch: expected kind %0d buttons %h scroll %0d last %0d",
                             want.kind, want.buttons, want.scroll, want.last_flag);
                    $display("                actual   kind %0d buttons %h scroll %0d last %0d",
                             kind, buttons, scroll, last_flag);
                end
                return;
            end
            case (want.kind)
                EV_PRESS:   press_seen++;
                EV_REPEAT:  repeat_seen++;
                EV_RELEASE: release_seen++;
                default:    ;
            endcase
            if (want.scroll) begin
                scroll_seen++;
            end
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// top-level testbench for button_edge_autorepeat_events_top
// depends on bea_pkg, button_event_scoreboard_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_top;

    import button_event_scoreboard_pkg::*;

    // pad bit groups: the 14 wired bits and the ignored rest
    localparam logic [31:0] USED_PAD_MASK   = 32'hFF00007E;
    localparam logic [31:0] UNUSED_PAD_MASK = 32'h00FFFF81;
    // single wired bits used by the directed part
    localparam logic [31:0] PAD_BTN12       = 32'h00000008;
    localparam logic [31:0] PAD_BTN14       = 32'h00000020;
    localparam logic [31:0] PAD_BTN6        = 32'h40000000;

    localparam int RESET_CYCLES     = 5;
    localparam int RANDOM_TICKS     = 800;
    localparam int MAX_GAP          = 16;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int HOLD_OFF_AT      = 200;
    localparam int DRAIN_PAUSE_AT   = 450;
    localparam int DRAIN_CYCLES     = 32;
    localparam int CYCLE_LIMIT      = 400000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_pad_word;
    logic        s_rapid_mode;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_event_kind;
    logic [15:0] m_event_buttons;
    logic        m_fast_scroll;
    logic        m_last_event;

    button_event_scoreboard sb;

    // run state; the hold-off flags are shared between the sender and the receiver
    int ticks_sent   = 0;
    int events_taken = 0;
    bit hold_off_req = 1'b0;
    bit holding_off  = 1'b0;
    bit s_burst      = 1'b0;
    bit m_burst      = 1'b0;
    int cycles       = 0;

    button_edge_autorepeat_events_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pad_word      (s_pad_word),
        .s_rapid_mode    (s_rapid_mode),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (m_event_kind),
        .m_event_buttons (m_event_buttons),
        .m_fast_scroll   (m_fast_scroll),
        .m_last_event    (m_last_event)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // offer one poll tick and wait for its transaction
    task automatic send_tick(input logic [31:0] pad, input logic fast);
        int gap;
        // every 64 ticks the sender may switch to a stretch without gaps
        if (ticks_sent % 64 == 0) begin
            s_burst = ($urandom_range(0, 3) == 0);
        end
        if (ticks_sent == HOLD_OFF_AT) begin
            hold_off_req = 1'b1;
        end
        if (ticks_sent == DRAIN_PAUSE_AT) begin
            // pause until every outstanding event has been taken
            s_valid <= 1'b0;
            do @(posedge aclk); while (sb.pending() != 0);
        end else begin
            // keep the input busy while the receiver holds off, so the queue fills
            gap = (s_burst || holding_off || hold_off_req) ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid      <= 1'b1;
        s_pad_word   <= pad;
        s_rapid_mode <= fast;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(pad, fast);
        ticks_sent++;
    endtask

    // stimulus
    initial begin
        logic [31:0] pattern;
        int          len;
        int          remaining;
        int          seg_kind;
        int          fast_mode;
        int          directed_ticks;
        sb = new();
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_pad_word   <= '0;
        s_rapid_mode <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // not armed yet: buttons down are ignored, all-up arms the block
        send_tick(USED_PAD_MASK, 1'b0);
        send_tick(32'hFFFFFFFF, 1'b1);
        send_tick(UNUSED_PAD_MASK, 1'b0);
        // press, second press, release
        send_tick(PAD_BTN12, 1'b0);
        send_tick(PAD_BTN12 | PAD_BTN14, 1'b0);
        send_tick(PAD_BTN14, 1'b0);
        // release and press in one tick, then a hold with bit 6 so the repeat is suppressed
        send_tick(PAD_BTN6, 1'b0);
        repeat (9) send_tick(PAD_BTN6, 1'b0);
        // swap back to a plain button and hold it until it repeats
        send_tick(PAD_BTN12, 1'b1);
        repeat (9) send_tick(PAD_BTN12, 1'b1);
        // all wired bits at once, then all up
        send_tick(USED_PAD_MASK, 1'b0);
        send_tick(32'h00000000, 1'b1);
        directed_ticks = ticks_sent;

        // random part: mostly held button sets with noise on the ignored bits,
        // now and then a long hold for fast repeat and fast scroll, some raw noise
        while (ticks_sent - directed_ticks < RANDOM_TICKS) begin
            seg_kind = $urandom_range(0, 99);
            if (seg_kind < 15) begin
                len = $urandom_range(1, 4);
                repeat (len) send_tick($urandom(), 1'($urandom_range(0, 1)));
            end else begin
                case ($urandom_range(0, 4))
                    0:       pattern = '0;
                    1:       pattern = USED_PAD_MASK;
                    2:       pattern = $urandom() & USED_PAD_MASK;
                    default: pattern = $urandom() & $urandom() & $urandom() & USED_PAD_MASK;
                endcase
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(160, 240)
                                                   : $urandom_range(1, 10);
                // keep the total close to the planned tick count
                remaining = RANDOM_TICKS - (ticks_sent - directed_ticks);
                if (len > remaining) begin
                    len = remaining;
                end
                fast_mode = $urandom_range(0, 2);
                repeat (len) begin
                    send_tick(pattern | ($urandom() & UNUSED_PAD_MASK),
                              (fast_mode == 2) ? 1'($urandom_range(0, 1))
                                               : 1'(fast_mode));
                end
            end
        end
        s_valid <= 1'b0;

        // drain, then wait on for any stray event
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d poll ticks: %0d press, %0d repeat, %0d release events",
                 ticks_sent, sb.press_seen, sb.repeat_seen, sb.release_seen);
        $display("%0d events with fast scroll, %0d repeats suppressed by bit 6, %0d mismatches",
                 sb.scroll_seen, sb.suppressed_repeats, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // event receiver with random stalls and one long hold-off
    initial begin
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (events_taken % 64 == 0) begin
                m_burst = ($urandom_range(0, 3) == 0);
            end
            if (hold_off_req) begin
                // long stretch with ready low, counted here in cycles
                hold_off_req = 1'b0;
                holding_off  = 1'b1;
                m_ready <= 1'b0;
                for (int c = 0; c < LONG_HOLD_CYCLES; c++) @(posedge aclk);
                holding_off = 1'b0;
            end else begin
                gap = m_burst ? 0 : $urandom_range(0, MAX_GAP);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_event(m_event_kind, m_event_buttons, m_fast_scroll, m_last_event);
            events_taken++;
        end
    end

    // watchdog on the whole run
    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d events outstanding",
                         cycles, sb.pending());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule

// ===== button_edge_autorepeat_events_top.f =====
+incdir+design
design/bea_pkg.sv
design/bea_front.sv
design/bea_queue.sv
design/bea_back.sv
design/button_edge_autorepeat_events_top.sv
tb/sv/button_event_scoreboard_pkg.sv
tb/sv/tb_top.sv
